/* hw/rtl/mset_pkg.sv */
// ----------------------------------------------------------------------------
// mset_pkg
// Shared constants, codes and types of the expiry timer bank.
// ----------------------------------------------------------------------------
package mset_pkg;

    localparam int SLOTS_DEF      = 16;
    localparam int COUNT_BITS_DEF = 32;

    localparam int KIND_W     = 2;
    localparam int SLOT_FW    = 4;
    localparam int DURATION_W = 32;
    localparam int EVENT_W    = 8;
    localparam int ELAPSED_W  = 16;
    localparam int STATUS_W   = 2;

    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ARM    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DISARM = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CONFLICT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_DUR = 2'd2;

    // Control outcome of one slot visit during a tick sweep.
    typedef struct packed {
        logic fire;
        logic wr_en;
        logic clear_active;
    } t_alu_res;

endpackage

/* hw/rtl/mset_req_if.sv */
// ----------------------------------------------------------------------------
// mset_req_if
// Request channel: tick, arm and disarm beats.
// ----------------------------------------------------------------------------
interface mset_req_if
    import mset_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [KIND_W-1:0]     kind;
    logic [SLOT_FW-1:0]    slot;
    logic [DURATION_W-1:0] duration;
    logic                  periodic;
    logic [EVENT_W-1:0]    event_code;
    logic [ELAPSED_W-1:0]  elapsed;

    modport source (
        output valid, kind, slot, duration, periodic, event_code, elapsed,
        input  ready
    );
    modport sink (
        input  valid, kind, slot, duration, periodic, event_code, elapsed,
        output ready
    );
endinterface

/* hw/rtl/mset_rsp_if.sv */
// ----------------------------------------------------------------------------
// mset_rsp_if
// Response channel: status and expiry beats.
// ----------------------------------------------------------------------------
interface mset_rsp_if
    import mset_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                fired;
    logic [SLOT_FW-1:0]  fired_slot;
    logic [EVENT_W-1:0]  fired_event;
    logic                last;

    modport source (
        output valid, status, fired, fired_slot, fired_event, last,
        input  ready
    );
    modport sink (
        input  valid, status, fired, fired_slot, fired_event, last,
        output ready
    );
endinterface

/* hw/rtl/mset_ram.sv */
// ----------------------------------------------------------------------------
// mset_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mset_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/mset_slot_alu.sv */
// ----------------------------------------------------------------------------
// mset_slot_alu
// Compare-and-subtract unit shared by all slots during a tick sweep.
// ----------------------------------------------------------------------------
module mset_slot_alu
    import mset_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  i_active,
    input  logic                  i_repeat,
    input  logic [COUNT_BITS-1:0] i_remaining,
    input  logic [COUNT_BITS-1:0] i_reload,
    input  logic [ELAPSED_W-1:0]  i_elapsed,
    output t_alu_res              o_res,
    output logic [COUNT_BITS-1:0] o_count
);

    localparam int CW = (COUNT_BITS > ELAPSED_W) ? COUNT_BITS : ELAPSED_W;

    logic [CW-1:0] rem_ext;
    logic [CW-1:0] el_ext;
    logic [CW-1:0] diff;
    logic          above;

    assign rem_ext = CW'(i_remaining);
    assign el_ext  = CW'(i_elapsed);
    assign above   = rem_ext > el_ext;
    assign diff    = rem_ext - el_ext;

    always_comb begin
        o_res.fire         = i_active && !above;
        o_res.wr_en        = i_active && (above || i_repeat);
        o_res.clear_active = i_active && !above && !i_repeat;
        // Reload drops any overshoot.
        o_count = above ? diff[COUNT_BITS-1:0] : i_reload;
    end

endmodule

/* hw/rtl/multi_slot_expiry_timer_bank_core.sv */
// ----------------------------------------------------------------------------
// multi_slot_expiry_timer_bank_core
// Bank of one-shot and periodic timer slots swept on each tick beat.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Beat contents
//  ---------+-----+------------------------------------------------------
//  i_req    | in  | kind, slot, duration, periodic, event_code, elapsed
//  o_rsp    | out | status, fired, fired_slot, fired_event, last
//
// Arm and disarm are answered by one status beat. A tick sweeps the slot
// RAM one slot per cycle, unless an output stall holds it, through the
// shared compare/subtract unit, then posts the final beat from ST_FINISH.
// A fired slot is held in a pending register so its last flag is known; a
// stalled output freezes the sweep on the firing slot. Synchronous active-low
// reset clears all active marks; the slot RAM needs no clearing.
// ----------------------------------------------------------------------------
module multi_slot_expiry_timer_bank_core
    import mset_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mset_req_if.sink    i_req,
    mset_rsp_if.source  o_rsp
);

    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WORD_W  = 2 * COUNT_BITS + 1 + EVENT_W;
    localparam int REM_LO  = 0;
    localparam int EV_LO   = COUNT_BITS;
    localparam int REP_BIT = COUNT_BITS + EVENT_W;
    localparam int REL_LO  = COUNT_BITS + EVENT_W + 1;
    localparam int DW      = (COUNT_BITS > DURATION_W) ? COUNT_BITS : DURATION_W;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } t_state;

    t_state              r_state, n_state;
    logic [SLOTS-1:0]    r_active, n_active;
    logic [SLOT_W-1:0]   r_idx, n_idx;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic                r_pend_valid, n_pend_valid;
    logic [SLOT_FW-1:0]  r_pend_slot, n_pend_slot;
    logic [EVENT_W-1:0]  r_pend_event, n_pend_event;

    logic                r_o_valid, n_o_valid;
    logic [STATUS_W-1:0] r_o_status, n_o_status;
    logic                r_o_fired, n_o_fired;
    logic [SLOT_FW-1:0]  r_o_slot, n_o_slot;
    logic [EVENT_W-1:0]  r_o_event, n_o_event;
    logic                r_o_last, n_o_last;

    logic                ram_we;
    logic [SLOT_W-1:0]   ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [SLOT_W-1:0]   ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    t_alu_res            alu_res;
    logic [COUNT_BITS-1:0] alu_count;

    logic                out_free;
    logic                accept;
    logic                slot_in_range;
    logic [SLOT_W-1:0]   req_idx;
    logic [DW-1:0]       dur_ext;
    logic [DW-1:0]       mask_ext;
    logic [DW-1:0]       dur_sat;
    logic [COUNT_BITS-1:0] dur_cnt;
    logic                stall;

    mset_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    mset_slot_alu #(
        .COUNT_BITS (COUNT_BITS)
    ) u_alu (
        .i_active    (r_active[r_idx]),
        .i_repeat    (ram_rdata[REP_BIT]),
        .i_remaining (ram_rdata[REM_LO +: COUNT_BITS]),
        .i_reload    (ram_rdata[REL_LO +: COUNT_BITS]),
        .i_elapsed   (r_elapsed),
        .o_res       (alu_res),
        .o_count     (alu_count)
    );

    assign out_free      = !r_o_valid || o_rsp.ready;
    assign i_req.ready   = (r_state == ST_IDLE) && out_free;
    assign accept        = i_req.valid && i_req.ready;
    assign slot_in_range = 32'(i_req.slot) < 32'(SLOTS);
    assign req_idx       = SLOT_W'(i_req.slot);

    // Clamp the duration to the counter range.
    assign dur_ext  = DW'(i_req.duration);
    assign mask_ext = DW'({COUNT_BITS{1'b1}});
    assign dur_sat  = (dur_ext > mask_ext) ? mask_ext : dur_ext;
    assign dur_cnt  = dur_sat[COUNT_BITS-1:0];

    assign stall = alu_res.fire && r_pend_valid && !out_free;

    always_comb begin
        n_state      = r_state;
        n_active     = r_active;
        n_idx        = r_idx;
        n_elapsed    = r_elapsed;
        n_pend_valid = r_pend_valid;
        n_pend_slot  = r_pend_slot;
        n_pend_event = r_pend_event;
        n_o_valid    = r_o_valid && !o_rsp.ready;
        n_o_status   = r_o_status;
        n_o_fired    = r_o_fired;
        n_o_slot     = r_o_slot;
        n_o_event    = r_o_event;
        n_o_last     = r_o_last;
        ram_we       = 1'b0;
        ram_waddr    = r_idx;
        ram_wdata    = {ram_rdata[WORD_W-1:COUNT_BITS], alu_count};
        ram_raddr    = '0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_o_valid  = 1'b1;
                    n_o_fired  = 1'b0;
                    n_o_slot   = '0;
                    n_o_event  = '0;
                    n_o_last   = 1'b1;
                    n_o_status = STATUS_CONFLICT;
                    case (i_req.kind)
                        KIND_TICK: begin
                            n_o_valid    = 1'b0;
                            n_state      = ST_SWEEP;
                            n_idx        = '0;
                            n_elapsed    = i_req.elapsed;
                            n_pend_valid = 1'b0;
                        end
                        KIND_ARM: begin
                            if (i_req.duration == '0) begin
                                n_o_status = STATUS_ZERO_DUR;
                            end else if (slot_in_range && !r_active[req_idx]) begin
                                n_o_status        = STATUS_OK;
                                n_active[req_idx] = 1'b1;
                                ram_we            = 1'b1;
                                ram_waddr         = req_idx;
                                ram_wdata         = {dur_cnt, i_req.periodic,
                                                     i_req.event_code, dur_cnt};
                            end
                        end
                        KIND_DISARM: begin
                            if (slot_in_range && r_active[req_idx]) begin
                                n_o_status        = STATUS_OK;
                                n_active[req_idx] = 1'b0;
                            end
                        end
                        default: begin
                            n_o_status = STATUS_CONFLICT;
                        end
                    endcase
                end
            end

            ST_SWEEP: begin
                if (stall) begin
                    // Hold on this slot until the output frees up.
                    ram_raddr = r_idx;
                end else begin
                    ram_raddr = (r_idx == LAST_IDX) ? r_idx : r_idx + 1'b1;
                    ram_we    = alu_res.wr_en;
                    if (alu_res.clear_active) begin
                        n_active[r_idx] = 1'b0;
                    end
                    if (alu_res.fire) begin
                        if (r_pend_valid) begin
                            n_o_valid  = 1'b1;
                            n_o_status = STATUS_OK;
                            n_o_fired  = 1'b1;
                            n_o_slot   = r_pend_slot;
                            n_o_event  = r_pend_event;
                            n_o_last   = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_slot  = SLOT_FW'(r_idx);
                        n_pend_event = ram_rdata[EV_LO +: EVENT_W];
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end

            ST_FINISH: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = STATUS_OK;
                    n_o_fired  = r_pend_valid;
                    n_o_slot   = r_pend_valid ? r_pend_slot : '0;
                    n_o_event  = r_pend_valid ? r_pend_event : '0;
                    n_o_last   = 1'b1;
                    n_state    = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_active     <= '0;
            r_pend_valid <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_active     <= n_active;
            r_pend_valid <= n_pend_valid;
            r_o_valid    <= n_o_valid;
        end
        r_idx        <= n_idx;
        r_elapsed    <= n_elapsed;
        r_pend_slot  <= n_pend_slot;
        r_pend_event <= n_pend_event;
        r_o_status   <= n_o_status;
        r_o_fired    <= n_o_fired;
        r_o_slot     <= n_o_slot;
        r_o_event    <= n_o_event;
        r_o_last     <= n_o_last;
    end

    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.fired       = r_o_fired;
    assign o_rsp.fired_slot  = r_o_slot;
    assign o_rsp.fired_event = r_o_event;
    assign o_rsp.last        = r_o_last;

endmodule
